[sv/tdt_pkg.sv]
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types for the tile deduplication table.
// ----------------------------------------------------------------------------
package tdt_pkg;

	localparam int unsigned TILE_W  = 128;
	localparam int unsigned HALF_W  = 64;
	localparam int unsigned INDEX_W = 8;

	// One result beat as produced by the controller.
	typedef struct packed {
		logic [INDEX_W-1:0] tile_index;
		logic               is_new;
		logic               table_full;
	} tdt_result_t;

endpackage

[sv/tile_dedup_table_core.sv]
// ----------------------------------------------------------------------------
// tile_dedup_table_core
// Lookup-or-insert table for 8x8 tiles of 2-bit color indices.
// ----------------------------------------------------------------------------
// One tile beat on the input channel yields exactly one result beat.
// With deduplication on, the stored tiles are read from a single tile RAM,
// one entry per cycle in insertion order, and the first exact match returns
// its index. On a miss, or with deduplication off, the tile is appended and
// the new index returned; when all MAX_TILES entries are used the tile is
// dropped and table_full is set.
// A scan reads the stored entries one at a time through the single RAM read
// port, and the result then moves through the controller's done state into
// the output register. One tile is in work at a time; input is taken again
// the cycle after the result has moved into the output register.
// The output register holds a result while out_ready is low; a finished
// result waits in the controller until the register frees up.
// Reset empties the table (entry count zero) and sets dedup_enable to 1.
// The configuration channel is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module tile_dedup_table_core #(
	parameter int unsigned MAX_TILES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [tdt_pkg::HALF_W-1:0]   tile_low_half,
	input  logic [tdt_pkg::HALF_W-1:0]   tile_high_half,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tdt_pkg::INDEX_W-1:0]  tile_index,
	output logic                         is_new,
	output logic                         table_full
);

	import tdt_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_TILES);

	logic                dedup_enable_q;
	logic                out_valid_q;
	tdt_result_t         out_q;

	logic                res_valid;
	logic                res_ready;
	tdt_result_t         res;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [TILE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [TILE_W-1:0]   ram_rdata;

	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dedup_enable_q <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				dedup_enable_q <= cfg_data;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign tile_index = out_q.tile_index;
	assign is_new     = out_q.is_new;
	assign table_full = out_q.table_full;

	tdt_ctrl #(
		.MAX_TILES (MAX_TILES)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.dedup_enable   (dedup_enable_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.tile_low_half  (tile_low_half),
		.tile_high_half (tile_high_half),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.res            (res),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata)
	);

	tdt_ram #(
		.WIDTH (TILE_W),
		.DEPTH (MAX_TILES)
	) u_tile_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[sv/tdt_ram.sv]
// ----------------------------------------------------------------------------
// tdt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tdt_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/tdt_ctrl.sv]
// ----------------------------------------------------------------------------
// tdt_ctrl
// Scan sequencer: with dedup on, walks the stored tiles in insertion order and
// compares each against the held tile; appends on a miss, or with dedup off, while the table has room.
// ----------------------------------------------------------------------------
module tdt_ctrl #(
	parameter int unsigned MAX_TILES = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   dedup_enable,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [tdt_pkg::HALF_W-1:0]             tile_low_half,
	input  logic [tdt_pkg::HALF_W-1:0]             tile_high_half,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output tdt_pkg::tdt_result_t                   res,
	output logic                                   ram_we,
	output logic [$clog2(MAX_TILES)-1:0]           ram_waddr,
	output logic [tdt_pkg::TILE_W-1:0]             ram_wdata,
	output logic                                   ram_re,
	output logic [$clog2(MAX_TILES)-1:0]           ram_raddr,
	input  logic [tdt_pkg::TILE_W-1:0]             ram_rdata
);

	import tdt_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_TILES);
	localparam int unsigned CNT_W = $clog2(MAX_TILES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [HALF_W-1:0]  tile_lo_q;
	logic [HALF_W-1:0]  tile_hi_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rd_addr_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;

	logic               rd_en;
	logic               match;
	logic               last;
	logic               full;
	logic               append;
	logic [IDX_W-1:0]   sel_idx;
	logic [IDX_W+INDEX_W-1:0] sel_ext;

	assign in_ready = (state_q == ST_IDLE);
	assign rd_en    = (state_q == ST_SCAN) && (rd_addr_q < count_q);
	assign match    = vld_s1 && (ram_rdata == {tile_hi_q, tile_lo_q});
	assign last     = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;
	assign full     = (count_q == CNT_W'(MAX_TILES));

	assign res_valid = (state_q == ST_DONE);
	assign append    = res_valid && res_ready && !hit_q && !full;

	assign ram_re    = rd_en;
	assign ram_raddr = rd_addr_q[IDX_W-1:0];
	assign ram_we    = append;
	assign ram_waddr = count_q[IDX_W-1:0];
	assign ram_wdata = {tile_hi_q, tile_lo_q};

	// The index field carries the low bits of the entry index.
	assign sel_idx = hit_q ? hit_idx_q : (full ? '0 : count_q[IDX_W-1:0]);
	assign sel_ext = {{INDEX_W{1'b0}}, sel_idx};

	always_comb begin
		res.tile_index = sel_ext[INDEX_W-1:0];
		res.is_new     = !hit_q && !full;
		res.table_full = !hit_q && full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			rd_addr_q <= '0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1    <= 1'b0;
					rd_addr_q <= '0;
					hit_q     <= 1'b0;
					if (in_valid) begin
						if (dedup_enable && (count_q != '0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					// One read issued per cycle; its data is compared in the next cycle.
					vld_s1    <= rd_en;
					rd_addr_q <= rd_addr_q + CNT_W'(rd_en);
					if (match) begin
						hit_q   <= 1'b1;
						vld_s1  <= 1'b0;
						state_q <= ST_DONE;
					end else if (vld_s1 && last) begin
						hit_q   <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						if (append) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			tile_lo_q <= tile_low_half;
			tile_hi_q <= tile_high_half;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= rd_addr_q[IDX_W-1:0];
			if (match) begin
				hit_idx_q <= idx_s1;
			end
		end
	end

endmodule

[sim/tb_tile_dedup_table_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_dedup_table_core
// Self-checking bench for the tile deduplication table.
// ----------------------------------------------------------------------------
// Tiles are pushed through the valid/ready input while the result channel
// stalls at random. A tracker keeps its own copy of the tile store and the
// dedup setting, predicts the lookup-or-insert outcome of every accepted
// tile, and checks each result beat against it in order. The run toggles
// dedup between phases, mixes repeated tiles, near misses and fresh random
// tiles, and drives the table well past full.
// ----------------------------------------------------------------------------
module tb_tile_dedup_table_core;
	import tdt_pkg::*;

	localparam int unsigned TABLE_DEPTH = 256;
	localparam int unsigned STALL_LIMIT = 20 * (TABLE_DEPTH + 3);
	localparam int unsigned IDLE_PCT    = 26;

	typedef logic [TILE_W-1:0] tile_bits_t;   // {high half, low half}

	class tile_table_tracker;
		logic [HALF_W-1:0] low_store  [TABLE_DEPTH];
		logic [HALF_W-1:0] high_store [TABLE_DEPTH];
		int unsigned       entry_count;
		bit                dedup_on;
		tdt_result_t       expected_results [$];
		int unsigned       errors;
		int unsigned       appended;
		int unsigned       matched;
		int unsigned       dropped;
		int unsigned       setting_writes;

		function new();
			entry_count    = 0;
			dedup_on       = 1'b1;
			errors         = 0;
			appended       = 0;
			matched        = 0;
			dropped        = 0;
			setting_writes = 0;
		endfunction

		function void set_dedup(bit enable);
			dedup_on = enable;
			setting_writes++;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		// Predicts the result of one accepted tile and updates the store.
		function void accept_tile(logic [HALF_W-1:0] lo, logic [HALF_W-1:0] hi);
			tdt_result_t want;
			int          hit;
			hit = -1;
			if (dedup_on) begin
				for (int k = 0; k < int'(entry_count); k++) begin
					if (hit < 0 && low_store[k] == lo && high_store[k] == hi)
						hit = k;
				end
			end
			if (hit >= 0) begin
				want.tile_index = INDEX_W'(hit);
				want.is_new     = 1'b0;
				want.table_full = 1'b0;
				matched++;
			end else if (entry_count >= TABLE_DEPTH) begin
				want.tile_index = '0;
				want.is_new     = 1'b0;
				want.table_full = 1'b1;
				dropped++;
			end else begin
				low_store[entry_count]  = lo;
				high_store[entry_count] = hi;
				want.tile_index = INDEX_W'(entry_count);
				want.is_new     = 1'b1;
				want.table_full = 1'b0;
				entry_count++;
				appended++;
			end
			expected_results.insert(expected_results.size(), want);
		endfunction

		function void check_result(logic [INDEX_W-1:0] idx, logic nw, logic full);
			tdt_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat: expected none, got index %0d new %b full %b",
					$time, idx, nw, full);
				return;
			end
			want = expected_results.pop_front();
			if (idx !== want.tile_index || nw !== want.is_new || full !== want.table_full) begin
				errors++;
				$display("%0t: expected index %0d new %b full %b, got index %0d new %b full %b",
					$time, want.tile_index, want.is_new, want.table_full, idx, nw, full);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n         = 1'b0;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_data       = 1'b0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [HALF_W-1:0]    tile_low_half  = '0;
	logic [HALF_W-1:0]    tile_high_half = '0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [INDEX_W-1:0]   tile_index;
	logic                 is_new;
	logic                 table_full;

	tile_table_tracker    tracker;
	tile_bits_t           sent_tiles [$];
	bit                   steady = 1'b0;
	int unsigned          quiet_cycles = 0;

	tile_dedup_table_core #(
		.MAX_TILES(TABLE_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.tile_low_half (tile_low_half),
		.tile_high_half(tile_high_half),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tile_index    (tile_index),
		.is_new        (is_new),
		.table_full    (table_full)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.accept_tile(tile_low_half, tile_high_half);
			if (out_valid && out_ready)
				tracker.check_result(tile_index, is_new, table_full);
			if (cfg_valid && cfg_ready)
				tracker.set_dedup(cfg_data);
		end
	end

	// Ends the run if no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
			$display("tile_dedup_table_core: mismatch");
			$finish;
		end
	end

	task automatic send_tile(input tile_bits_t t);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid       <= 1'b1;
		tile_low_half  <= t[HALF_W-1:0];
		tile_high_half <= t[TILE_W-1:HALF_W];
		sent_tiles.insert(sent_tiles.size(), t);
		do @(posedge clk); while (!in_ready);
	endtask

	// The block holds one tile at a time, so no result pending means idle.
	task automatic write_dedup(input bit enable);
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (2) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= enable;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly repeats of earlier tiles and one-bit near misses, so that the
	// search finds hits at every depth; the rest are extremes and fresh tiles.
	task automatic next_tile(input int unsigned repeat_pct, output tile_bits_t t);
		int unsigned roll;
		int unsigned flip;
		roll = $urandom_range(99);
		if (roll < repeat_pct && sent_tiles.size() > 0) begin
			t = sent_tiles[$urandom_range(sent_tiles.size() - 1)];
		end else if (roll < repeat_pct + 10 && sent_tiles.size() > 0) begin
			t = sent_tiles[$urandom_range(sent_tiles.size() - 1)];
			flip = $urandom_range(TILE_W - 1);
			t[flip] = ~t[flip];
		end else if (roll < repeat_pct + 15) begin
			case ($urandom_range(3))
				0: t = '0;
				1: t = '1;
				2: t = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
				default: t = {64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};
			endcase
		end else begin
			t = {$urandom, $urandom, $urandom, $urandom};
		end
	endtask

	task automatic run_phase(input int unsigned items, input int unsigned repeat_pct);
		tile_bits_t t;
		for (int unsigned i = 0; i < items; i++) begin
			next_tile(repeat_pct, t);
			send_tile(t);
		end
	endtask

	initial begin
		tracker = new;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed tiles under the reset setting, where dedup is on.
		send_tile({64'h0, 64'h0});
		send_tile({64'h0, 64'h0});
		send_tile({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_tile({64'hFFFF_FFFF_FFFF_FFFF, 64'h0});
		send_tile({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
		send_tile({64'h0, 64'h0});
		send_tile({64'h0, 64'h8000_0000_0000_0000});
		send_tile({64'h8000_0000_0000_0000, 64'h0});
		send_tile({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_tile({64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
		send_tile({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
		send_tile({64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});

		// With dedup off duplicates are stored; once back on, the first copy wins.
		write_dedup(1'b0);
		send_tile({64'h0, 64'h0});
		send_tile({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		write_dedup(1'b1);
		send_tile({64'h0, 64'h0});
		send_tile({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});

		run_phase(300, 60);

		write_dedup(1'b0);
		steady = 1'b1;
		run_phase(100, 50);
		steady = 1'b0;

		// The table fills up during this phase and then starts dropping tiles.
		write_dedup(1'b1);
		run_phase(250, 50);

		write_dedup(1'b0);
		run_phase(80, 40);

		write_dedup(1'b1);
		run_phase(200, 60);

		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("Covered %0d tiles across %0d dedup setting writes, table filled to %0d entries.",
			tracker.appended + tracker.matched + tracker.dropped, tracker.setting_writes,
			tracker.entry_count);
		$display("Outcomes: %0d appended, %0d matched, %0d dropped on a full table.",
			tracker.appended, tracker.matched, tracker.dropped);
		if (tracker.errors == 0)
			$display("tile_dedup_table_core: match");
		else
			$display("tile_dedup_table_core: mismatch");
		$finish;
	end

endmodule

[sim.f]
sv/tdt_pkg.sv
sv/tdt_ram.sv
sv/tdt_ctrl.sv
sv/tile_dedup_table_core.sv
sim/tb_tile_dedup_table_core.sv
